@@ hdl/mrrc_pkg.sv @@
// Package: constants, types and the rank function for the route classifier.
`default_nettype none
package mrrc_pkg;
	localparam int RouteEntries = 16;
	localparam int IdxW = $clog2(RouteEntries);
	localparam int CntW = $clog2(RouteEntries + 1);
	localparam int MaxOut = 16;
	localparam int OutCntW = $clog2(MaxOut + 1);

	localparam logic [1:0] Q_ANY = 2'd1;
	localparam logic [1:0] Q_NOT = 2'd2;
	localparam logic [1:0] Q_NONE = 2'd3;
	localparam logic [1:0] LT_ANY = 2'd2;
	localparam logic [15:0] LINK_WILD = 16'hFFFF;
	localparam logic [1:0] TT_IF = 2'd0;
	localparam logic [1:0] TT_EDGE = 2'd1;

	localparam logic CMD_ADD = 1'b0;

	localparam logic [2:0] ST_IF = 3'd0;
	localparam logic [2:0] ST_EDGE = 3'd1;
	localparam logic [2:0] ST_DROP = 3'd2;
	localparam logic [2:0] ST_NOROUTE = 3'd3;
	localparam logic [2:0] ST_ADDED = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;
	localparam logic [2:0] ST_BADTYPE = 3'd6;

	localparam logic [1:0] BR_NONE = 2'd0;
	localparam logic [1:0] BR_EN = 2'd1;

	localparam logic CFG_STATE = 1'b0;
	localparam logic CFG_BATCH = 1'b1;

	typedef struct packed {
		logic [15:0] tid;
		logic [1:0]  tt;
		logic [15:0] lid;
		logic [1:0]  lt;
		logic [1:0]  dq;
		logic [1:0]  sq;
	} attr_t;

	typedef struct packed {
		logic [47:0] smac;
		logic [47:0] dmac;
		attr_t       attr;
	} route_t;

	typedef struct packed {
		logic [IdxW-1:0] idx;
		logic [1:0]      typ;
		logic [15:0]     id;
		logic [2:0]      status;
		logic            last;
	} result_t;

	function automatic logic [3:0] route_rank(input logic seq, input logic deq,
		input attr_t a, input logic [1:0] ft, input logic [15:0] fid);
		logic [3:0] r;
		r = 4'd0;
		if (a.lt != LT_ANY && (a.lt != ft || (a.lid != fid && a.lid != LINK_WILD)))
			return 4'd0;
		if (a.dq == Q_ANY && a.sq == Q_ANY) r = 4'd3;
		if (seq && a.sq != Q_NOT) begin
			if (a.dq == Q_ANY) begin
				if (r < 4'd6) r = 4'd6;
			end else if (a.dq != Q_NOT && deq) r = 4'd8;
		end
		if (deq && a.dq != Q_NOT) begin
			if (a.sq == Q_ANY) begin
				if (r < 4'd6) r = 4'd6;
			end else if (a.sq != Q_NOT && seq) r = 4'd8;
		end
		if (a.dq == Q_NOT && !deq) begin
			if (a.sq == Q_ANY) begin
				if (r < 4'd5) r = 4'd5;
			end else if (a.sq != Q_NOT && seq) begin
				if (r < 4'd7) r = 4'd7;
			end
		end
		if (a.sq == Q_NOT && !seq) begin
			if (a.dq == Q_ANY) begin
				if (r < 4'd5) r = 4'd5;
			end else if (a.dq != Q_NOT && deq) begin
				if (r < 4'd7) r = 4'd7;
			end
		end
		if (seq && a.dq == Q_NONE && r < 4'd4) r = 4'd4;
		return r;
	endfunction
endpackage
`default_nettype wire

@@ hdl/mrrc_table.sv @@
// Route table memory with one write port and one registered read port.
`default_nettype none
module mrrc_table (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [mrrc_pkg::IdxW-1:0] waddr,
	input  wire mrrc_pkg::route_t      wdata,
	input  wire logic [mrrc_pkg::IdxW-1:0] raddr,
	output mrrc_pkg::route_t           rdata
);
	import mrrc_pkg::*;
	route_t mem [RouteEntries];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/mac_route_rank_classifier_top.sv @@
// Route classifier top: sequencer over the route table with output register.
// Add: accept moves to S_SINGLE, which loads the result into the output register.
// Classify: a sweep of route_count reads finds the top rank, a second sweep emits its
// matches (no second sweep with no match), one entry a cycle (table read port) unless stalled.
// One item at a time; output stalls hold the sweep. Reset clears route count, bridge
// registers and control; table contents are undefined until written, only written slots read.
`default_nettype none
module mac_route_rank_classifier_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output wire logic        in_ready,
	input  wire logic        command,
	input  wire logic [47:0] src_mac,
	input  wire logic [47:0] dst_mac,
	input  wire logic [1:0]  src_qualifier,
	input  wire logic [1:0]  dst_qualifier,
	input  wire logic [1:0]  link_type,
	input  wire logic [15:0] link_id,
	input  wire logic [1:0]  target_type,
	input  wire logic [15:0] target_id,
	output wire logic        out_valid,
	input  wire logic        out_ready,
	output wire logic [3:0]  route_index,
	output wire logic [1:0]  out_type,
	output wire logic [15:0] out_id,
	output wire logic [2:0]  status,
	output wire logic        last
);
	import mrrc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_EMIT  = 5'b00100,
		S_SINGLE = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	logic [1:0] br_state_q;
	logic br_batch_q;
	logic [CntW-1:0] count_q;
	logic [47:0] fsrc_q, fdst_q;
	logic [1:0] ftype_q;
	logic [15:0] fid_q;
	logic pass_q;              // 0 finds top rank, 1 emits
	logic [CntW-1:0] rptr_q;   // next read address
	logic rvld_s1;             // table data valid
	logic [IdxW-1:0] ridx_s1;
	logic [3:0] top_q;
	logic [OutCntW-1:0] total_q, sent_q;
	result_t single_q;
	result_t out_q;
	logic out_valid_q;

	route_t rdata, wdata;
	logic we;
	logic [3:0] rank;
	logic [2:0] st;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign route_index = 4'(out_q.idx);
	assign out_type = out_q.typ;
	assign out_id = out_q.id;
	assign status = out_q.status;
	assign last = out_q.last;

	logic accept;
	assign accept = in_valid && in_ready;
	assign we = accept && command == CMD_ADD && count_q < CntW'(RouteEntries);
	assign wdata = '{smac: src_mac, dmac: dst_mac, attr: '{tid: target_id,
		tt: target_type, lid: link_id, lt: link_type, dq: dst_qualifier,
		sq: src_qualifier}};

	// stall reads while output is full in emit pass
	logic out_free, advance;
	assign out_free = !out_valid_q || out_ready;
	assign advance = (state_q == S_SCAN) && (!pass_q || out_free);

	// on a stall, re-read the held entry so table data stays put
	logic [IdxW-1:0] raddr;
	assign raddr = advance ? rptr_q[IdxW-1:0] : ridx_s1;

	mrrc_table u_table (
		.clk(clk), .we(we), .waddr(count_q[IdxW-1:0]), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign rank = route_rank(rdata.smac == fsrc_q, rdata.dmac == fdst_q, rdata.attr,
		ftype_q, fid_q);

	always_comb begin
		unique case (rdata.attr.tt)
			TT_IF:   st = ST_IF;
			TT_EDGE: begin
				if (br_state_q == BR_NONE) st = ST_DROP;
				else if (br_batch_q) st = ST_EDGE;
				else if (br_state_q == BR_EN) st = ST_EDGE;
				else st = ST_DROP;
			end
			default: st = ST_BADTYPE;
		endcase
	end

	logic hit;
	assign hit = rvld_s1 && pass_q && rank == top_q && sent_q < total_q && out_free;

	logic out_load;
	assign out_load = hit || (state_q == S_SINGLE && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			br_state_q <= BR_NONE;
			br_batch_q <= 1'b0;
			count_q <= '0;
			fsrc_q <= '0;
			fdst_q <= '0;
			ftype_q <= '0;
			fid_q <= '0;
			out_valid_q <= 1'b0;
			rvld_s1 <= 1'b0;
			ridx_s1 <= '0;
			pass_q <= 1'b0;
			rptr_q <= '0;
			top_q <= '0;
			total_q <= '0;
			sent_q <= '0;
			single_q <= '0;
			out_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_STATE) br_state_q <= cfg_data;
				else br_batch_q <= cfg_data[0];
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					if (command == CMD_ADD) begin
						if (we) begin
							count_q <= count_q + 1'b1;
							single_q <= '{idx: count_q[IdxW-1:0], typ: target_type,
								id: target_id, status: ST_ADDED, last: 1'b1};
						end else
							single_q <= '{idx: '0, typ: 2'd0, id: 16'd0,
								status: ST_FULL, last: 1'b1};
						state_q <= S_SINGLE;
					end else begin
						fsrc_q <= src_mac;
						fdst_q <= dst_mac;
						ftype_q <= link_type;
						fid_q <= link_id;
						rptr_q <= '0;
						pass_q <= 1'b0;
						top_q <= '0;
						total_q <= '0;
						sent_q <= '0;
						rvld_s1 <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!pass_q) begin
						if (rvld_s1) begin
							if (rank > top_q) begin
								top_q <= rank;
								total_q <= OutCntW'(1);
							end else if (rank == top_q && total_q < OutCntW'(MaxOut))
								total_q <= total_q + 1'b1;
						end
					end else if (hit) begin
						out_q <= '{idx: ridx_s1, typ: rdata.attr.tt, id: rdata.attr.tid,
							status: st, last: sent_q + 1'b1 == total_q};
						sent_q <= sent_q + 1'b1;
					end
					if (advance) begin
						rvld_s1 <= rptr_q < count_q;
						ridx_s1 <= rptr_q[IdxW-1:0];
						if (rptr_q < count_q) rptr_q <= rptr_q + 1'b1;
						else if (!rvld_s1) begin
							// sweep finished, data drained
							if (!pass_q) begin
								if (top_q == 4'd0) begin
									single_q <= '{idx: '0, typ: 2'd0, id: 16'd0,
										status: ST_NOROUTE, last: 1'b1};
									state_q <= S_SINGLE;
								end else begin
									pass_q <= 1'b1;
									rptr_q <= '0;
								end
							end else state_q <= S_DONE;
						end
					end else rvld_s1 <= rvld_s1 && !(pass_q && out_free);
				end
				S_SINGLE: if (out_free) begin
					out_q <= single_q;
					state_q <= S_DONE;
				end
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ verif/mac_route_rank_classifier_top_test.sv @@
// Testbench for the route rank classifier: scoreboard class, drivers and checker.
`default_nettype none
module mac_route_rank_classifier_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mrrc_pkg::*;

	localparam int WatchLimit = 20000;

	typedef struct {
		logic [3:0]  idx;
		logic [1:0]  typ;
		logic [15:0] id;
		logic [2:0]  status;
		logic        last;
	} route_result_t;

	typedef struct {
		logic        cmd;
		logic [47:0] smac;
		logic [47:0] dmac;
		logic [1:0]  sq;
		logic [1:0]  dq;
		logic [1:0]  lt;
		logic [15:0] lid;
		logic [1:0]  tt;
		logic [15:0] tid;
	} frame_cmd_t;

	int mismatches = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	class route_scoreboard;
		frame_cmd_t    tbl_route[RouteEntries];
		int            count;
		logic [1:0]    br_state;
		logic          br_batched;
		route_result_t pending[$];

		function void clear();
			count = 0;
			br_state = '0;
			br_batched = 1'b0;
			pending.delete();
		endfunction

		function int rank_of(int s, frame_cmd_t f);
			frame_cmd_t a;
			logic seq, deq;
			int r;
			a = tbl_route[s];
			seq = a.smac == f.smac;
			deq = a.dmac == f.dmac;
			r = 0;
			if (a.lt != LT_ANY && (a.lt != f.lt || (a.lid != f.lid && a.lid != LINK_WILD)))
				return 0;
			if (a.dq == Q_ANY && a.sq == Q_ANY) r = 3;
			if (seq && a.sq != Q_NOT) begin
				if (a.dq == Q_ANY) r = (r < 6) ? 6 : r;
				else if (a.dq != Q_NOT && deq) r = 8;
			end
			if (deq && a.dq != Q_NOT) begin
				if (a.sq == Q_ANY) r = (r < 6) ? 6 : r;
				else if (a.sq != Q_NOT && seq) r = 8;
			end
			if (a.dq == Q_NOT && !deq) begin
				if (a.sq == Q_ANY) r = (r < 5) ? 5 : r;
				else if (a.sq != Q_NOT && seq) r = (r < 7) ? 7 : r;
			end
			if (a.sq == Q_NOT && !seq) begin
				if (a.dq == Q_ANY) r = (r < 5) ? 5 : r;
				else if (a.dq != Q_NOT && deq) r = (r < 7) ? 7 : r;
			end
			if (seq && a.dq == Q_NONE && r < 4) r = 4;
			return r;
		endfunction

		function void note_item(frame_cmd_t f);
			route_result_t e;
			int ranks[RouteEntries];
			int top, total, n;
			if (f.cmd == CMD_ADD) begin
				if (count >= RouteEntries) begin
					e = '{0, 0, 0, ST_FULL, 1};
				end else begin
					tbl_route[count] = f;
					e = '{count[3:0], f.tt, f.tid, ST_ADDED, 1};
					count++;
				end
				pending.push_back(e);
				return;
			end
			top = 0;
			for (int i = 0; i < count; i++) begin
				ranks[i] = rank_of(i, f);
				if (ranks[i] > top) top = ranks[i];
			end
			if (top == 0) begin
				e = '{0, 0, 0, ST_NOROUTE, 1};
				pending.push_back(e);
				return;
			end
			total = 0;
			for (int i = 0; i < count; i++) if (ranks[i] == top) total++;
			if (total > MaxOut) total = MaxOut;
			n = 0;
			for (int i = 0; i < count && n < total; i++) begin
				if (ranks[i] != top) continue;
				e.idx = i[3:0];
				e.typ = tbl_route[i].tt;
				e.id = tbl_route[i].tid;
				if (e.typ == TT_IF) e.status = ST_IF;
				else if (e.typ == TT_EDGE) begin
					if (br_state == BR_NONE) e.status = ST_DROP;
					else if (br_batched) e.status = ST_EDGE;
					else e.status = (br_state == BR_EN) ? ST_EDGE : ST_DROP;
				end else e.status = ST_BADTYPE;
				e.last = (n + 1 == total);
				pending.push_back(e);
				n++;
			end
		endfunction

		task check_result(route_result_t r);
			route_result_t e;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result idx", r.idx, 0);
				return;
			end
			e = pending.pop_front();
			if (r.idx !== e.idx) report_mismatch("route_index", r.idx, e.idx);
			if (r.typ !== e.typ) report_mismatch("out_type", r.typ, e.typ);
			if (r.id !== e.id) report_mismatch("out_id", r.id, e.id);
			if (r.status !== e.status) report_mismatch("status", r.status, e.status);
			if (r.last !== e.last) report_mismatch("last", r.last, e.last);
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	wire         cfg_ready;
	logic        cfg_index = 0;
	logic [1:0]  cfg_data = 0;
	logic        in_valid = 0;
	wire         in_ready;
	logic        command = 0;
	logic [47:0] src_mac = 0;
	logic [47:0] dst_mac = 0;
	logic [1:0]  src_qualifier = 0;
	logic [1:0]  dst_qualifier = 0;
	logic [1:0]  link_type = 0;
	logic [15:0] link_id = 0;
	logic [1:0]  target_type = 0;
	logic [15:0] target_id = 0;
	wire         out_valid;
	logic        out_ready = 0;
	wire  [3:0]  route_index;
	wire  [1:0]  out_type;
	wire  [15:0] out_id;
	wire  [2:0]  status;
	wire         last;

	mac_route_rank_classifier_top dut (.*);

	route_scoreboard routes = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 0;
	int idle_cycles = 0;
	logic [47:0] mac_pool[4];

	initial begin
		forever #5 clk = ~clk;
	end

	// accepted item bookkeeping and result checking
	always @(posedge clk) begin
		route_result_t r;
		if (arst_n) begin
			if (in_valid && in_ready) routes.note_item('{command, src_mac, dst_mac,
				src_qualifier, dst_qualifier, link_type, link_id, target_type, target_id});
			if (out_valid && out_ready) begin
				r = '{route_index, out_type, out_id, status, last};
				routes.check_result(r);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 0;
		else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (idle_cycles >= WatchLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == CFG_STATE) routes.br_state = val;
		else routes.br_batched = val[0];
		@(posedge clk);
	endtask

	task automatic send_item(input frame_cmd_t f);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid <= 1;
		command <= f.cmd;
		src_mac <= f.smac;
		dst_mac <= f.dmac;
		src_qualifier <= f.sq;
		dst_qualifier <= f.dq;
		link_type <= f.lt;
		link_id <= f.lid;
		target_type <= f.tt;
		target_id <= f.tid;
		do @(posedge clk); while (!in_ready);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (routes.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [47:0] pick_mac();
		if ($urandom_range(3) != 0) return mac_pool[2'($urandom_range(3))];
		return 48'({$urandom, $urandom});
	endfunction

	function automatic frame_cmd_t rand_item(bit add);
		frame_cmd_t f;
		f.cmd = !add;
		f.smac = pick_mac();
		f.dmac = pick_mac();
		f.sq = 2'($urandom_range(3));
		f.dq = 2'($urandom_range(3));
		f.lt = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
		case ($urandom_range(3))
			0: f.lid = LINK_WILD;
			1: f.lid = 16'($urandom);
			default: f.lid = 16'($urandom_range(3));
		endcase
		f.tt = ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
		f.tid = 16'($urandom);
		return f;
	endfunction

	task automatic fill_table(input int n);
		for (int i = 0; i < n; i++) send_item(rand_item(1));
	endtask

	initial begin
		frame_cmd_t f;
		int sent;
		mac_pool[0] = 48'h0;
		mac_pool[1] = 48'hFFFF_FFFF_FFFF;
		mac_pool[2] = 48'({$urandom, $urandom});
		mac_pool[3] = 48'hAAAA_5555_AAAA;
		routes.clear();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, extremes, each qualifier and destination type
		f = '{1, 48'h0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0};
		send_item(f);
		f = '{0, 48'hFFFF_FFFF_FFFF, 48'h0, Q_ANY, Q_ANY, LT_ANY, 16'h0, TT_IF, 16'hFFFF};
		send_item(f);
		f = '{0, 48'hFFFF_FFFF_FFFF, 48'h0, 0, Q_NONE, 0, LINK_WILD, TT_EDGE, 16'h1234};
		send_item(f);
		f = '{0, 48'h0, 48'hFFFF_FFFF_FFFF, Q_NOT, 0, 1, 16'h0, 2'd2, 16'h0};
		send_item(f);
		f = '{0, 48'h0, 48'h0, 0, Q_NOT, 2'd3, 16'hFFFE, 2'd3, 16'h8001};
		send_item(f);
		f = '{1, 48'hFFFF_FFFF_FFFF, 48'h0, 0, 0, 0, 16'h5, 0, 0};
		send_item(f);
		f = '{1, 48'h1, 48'hFFFF_FFFF_FFFF, 0, 0, 1, 16'hFFFF, 0, 0};
		send_item(f);
		f = '{1, 48'h0, 48'h0, 0, 0, 2'd3, 16'hFFFE, 0, 0};
		send_item(f);
		drain();
		write_reg(CFG_STATE, 2'd1);
		write_reg(CFG_BATCH, 2'd1);
		f = '{1, 48'hFFFF_FFFF_FFFF, 48'h0, 0, 0, 0, 16'h5, 0, 0};
		send_item(f);
		drain();
		write_reg(CFG_STATE, 2'd2);
		write_reg(CFG_BATCH, 2'd0);
		send_item(f);
		drain();
		write_reg(CFG_STATE, 2'd3);
		send_item(f);

		// random: fill table to 16 over phases, then mostly classify
		sent = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 70 : 0;
			recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 31 : 0;
			drain();
			write_reg(CFG_STATE, 2'($urandom_range(3)));
			write_reg(CFG_BATCH, 2'($urandom_range(1)));
			for (int k = 0; k < 80; k++) begin
				if (ph == 1 && k == 10) begin
					fork
						begin
							hold_off = 1;
							repeat (300) @(posedge clk);
							hold_off = 0;
						end
					join_none
				end
				send_item(rand_item(routes.count < 16 && $urandom_range(3) == 0 ||
					$urandom_range(19) == 0));
				sent++;
			end
		end
		drain();
		if (mismatches == 0 && routes.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
hdl/mrrc_pkg.sv
hdl/mrrc_table.sv
hdl/mac_route_rank_classifier_top.sv
verif/mac_route_rank_classifier_top_test.sv
